### hw/rtl/bdrd_pkg.sv
// Package for the box difference row derivative block.
// Holds shared widths, register codes and the front-to-back request type.
// No dependencies.
package bdrd_pkg;

    localparam int MAX_HALF_DEF     = 16;
    localparam int PIX_W            = 8;
    localparam int LEN_W            = 14;
    localparam int S_W              = 7;   // whole half length, up to MAX_HALF
    localparam int CNT_W            = 9;   // column count, up to 4*MAX_HALF+63
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [LEN_W-1:0]  FILTER_LEN_RESET = LEN_W'(1280);
    localparam logic [0:0]        REG_FILTER_LEN   = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic [S_W-1:0]   s;
        logic [7:0]       a;
        logic [CNT_W-1:0] cc;
    } item_t;

endpackage

### hw/rtl/bdrd_fifo.sv
// Short request queue between the front and back parts.
// Depends on bdrd_pkg for item_t.
module bdrd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bdrd_pkg::item_t din,
    output logic          full,
    input  logic          pop,
    output bdrd_pkg::item_t dout,
    output logic          empty
);
    import bdrd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/bdrd_front.sv
// Front part: configuration register, pixel intake, half-length decode
// and column counting. Depends on bdrd_pkg.
module bdrd_front #(
    parameter int MAX_HALF = bdrd_pkg::MAX_HALF_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdrd_pkg::ADDR_W-1:0]  paddr,
    input  logic [bdrd_pkg::DATA_W-1:0]  pwdata,
    output logic [bdrd_pkg::DATA_W-1:0]  prdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bdrd_pkg::PIX_W-1:0]   in_pixel,
    input  logic                         in_end,
    output logic                         q_push,
    output bdrd_pkg::item_t              q_item,
    input  logic                         q_full
);
    import bdrd_pkg::*;

    localparam int CNT_MAX  = 4 * MAX_HALF + 63;
    localparam int HALF_MAX = MAX_HALF * 256 + 255;

    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] cc_reg;
    logic [CNT_W-1:0] cc_inc;
    logic [15:0]      half_raw;
    logic [15:0]      half_c;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= FILTER_LEN_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_FILTER_LEN))
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FILTER_LEN) ? DATA_W'(len_reg) : '0;

    always_comb
    begin
        half_raw = 16'(len_reg >> 1);
        if (half_raw < 16'd256)
        begin
            half_c = 16'd256;
        end
        else if (half_raw > 16'(HALF_MAX))
        begin
            half_c = 16'(HALF_MAX);
        end
        else
        begin
            half_c = half_raw;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cc_inc   = (cc_reg < CNT_W'(CNT_MAX)) ? cc_reg + 1'b1 : cc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
        end
        else if (accept)
        begin
            cc_reg <= in_end ? '0 : cc_inc;
        end
    end

    assign q_push         = accept;
    assign q_item.pixel   = in_pixel;
    assign q_item.row_end = in_end;
    assign q_item.s       = half_c[8+S_W-1:8];
    assign q_item.a       = half_c[7:0];
    assign q_item.cc      = cc_inc;

endmodule

### hw/rtl/bdrd_back.sv
// Back part: pixel history memory, window sums, two serial dividers and
// the output register. Depends on bdrd_pkg.
module bdrd_back #(
    parameter int MAX_HALF = bdrd_pkg::MAX_HALF_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bdrd_pkg::item_t             q_item,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bdrd_pkg::PIX_W-1:0]  out_data,
    output logic                        out_last
);
    import bdrd_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF + 2;
    localparam int A_W   = $clog2(DEPTH);
    localparam int K_W   = $clog2(DEPTH + 1);
    localparam int IDX_W = CNT_W + 1;
    localparam int W_W   = S_W + 8;
    localparam int SUM_W = 23;
    localparam int NUM_W = SUM_W + 8;
    localparam int Q_W   = 17;
    localparam int BC_W  = $clog2(NUM_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [PIX_W-1:0] hist_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             rdv_reg;
    logic [K_W-1:0]   kd_reg;
    logic [K_W-1:0]   k_reg;
    logic [A_W-1:0]   wp_reg;
    logic [A_W-1:0]   wp_next;
    logic [A_W-1:0]   rd_addr;

    item_t            it_reg;
    logic             norm_reg;
    logic [S_W-1:0]   d_reg;

    logic [IDX_W-1:0] rlo_reg, rhi_reg, llo_reg, lhi_reg, lf_reg;
    logic [7:0]       ra_reg, la_reg;
    logic [W_W-1:0]   rw_reg, lw_reg;
    logic [SUM_W-1:0] rsum_reg, lsum_reg;

    logic [NUM_W-1:0] rnum_reg, lnum_reg;
    logic [W_W-1:0]   rrem_reg, lrem_reg;
    logic [Q_W-1:0]   rq_reg, lq_reg;
    logic [BC_W-1:0]  bc_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    // first-job decode for a freshly popped item and the flush start of it_reg
    logic             q_norm;
    logic [S_W-1:0]   q_dmin;
    logic [S_W-1:0]   it_dmin;
    logic [CNT_W-1:0] q_p, it_p;

    assign q_p    = q_item.cc - 1'b1;
    assign q_dmin = (CNT_W'(q_item.s) < q_p) ? q_item.s : S_W'(q_p);
    assign q_norm = (q_item.cc >= CNT_W'(q_item.s) + CNT_W'(2));
    assign it_p    = it_reg.cc - 1'b1;
    assign it_dmin = (CNT_W'(it_reg.s) < it_p) ? it_reg.s : S_W'(it_p);

    assign wp_next = (wp_reg == A_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        if ({1'b0, k_reg} <= (K_W+1)'(wp_reg))
        begin
            rd_addr = A_W'(wp_reg - A_W'(k_reg));
        end
        else
        begin
            rd_addr = A_W'((K_W+1)'(wp_reg) + (K_W+1)'(DEPTH) - (K_W+1)'(k_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hist_mem[wp_next] <= q_item.pixel;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // window setup for the current job
    logic [IDX_W-1:0] e_c, x_c;
    always_comb
    begin
        if (norm_reg)
        begin
            e_c = IDX_W'(it_reg.s) + 1'b1;
            x_c = IDX_W'(it_reg.cc) - IDX_W'(it_reg.s) - IDX_W'(2);
        end
        else
        begin
            e_c = IDX_W'(d_reg);
            x_c = IDX_W'(it_reg.cc) - 1'b1 - IDX_W'(d_reg);
        end
    end

    // per-tap contributions
    logic [IDX_W-1:0] kd_i;
    logic [15:0]      pix_whole;
    logic [15:0]      r_frac, l_frac;
    logic [SUM_W-1:0] r_add, l_add;
    always_comb
    begin
        kd_i      = IDX_W'(kd_reg);
        pix_whole = {rd_data_reg, 8'b0};
        r_frac    = rd_data_reg * ra_reg;
        l_frac    = rd_data_reg * la_reg;
        r_add     = '0;
        l_add     = '0;
        if (kd_i >= rlo_reg && kd_i <= rhi_reg)
        begin
            r_add = r_add + SUM_W'(pix_whole);
        end
        if (kd_i == '0)
        begin
            r_add = r_add + SUM_W'(r_frac);
        end
        if (kd_i >= llo_reg && kd_i <= lhi_reg)
        begin
            l_add = l_add + SUM_W'(pix_whole);
        end
        if (kd_i == lf_reg)
        begin
            l_add = l_add + SUM_W'(l_frac);
        end
    end

    // one restoring step for each divider
    logic [W_W:0] rrem_sh, lrem_sh;
    logic         rbit, lbit;
    always_comb
    begin
        rrem_sh = {rrem_reg, rnum_reg[NUM_W-1]};
        lrem_sh = {lrem_reg, lnum_reg[NUM_W-1]};
        rbit    = (rrem_sh >= {1'b0, rw_reg});
        lbit    = (lrem_sh >= {1'b0, lw_reg});
    end

    // final value: 128 + right - left, floored and clamped
    logic signed [Q_W+1:0] v_c;
    logic [PIX_W-1:0]      res_c;
    always_comb
    begin
        v_c = (Q_W+2)'(32768) + $signed({2'b0, rq_reg}) - $signed({2'b0, lq_reg});
        if (v_c < 0)
        begin
            res_c = '0;
        end
        else if (v_c[Q_W+1:8] > (Q_W-6)'(255))
        begin
            res_c = 8'd255;
        end
        else
        begin
            res_c = v_c[15:8];
        end
    end

    logic emit_go;
    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && (q_norm || (q_item.row_end && q_dmin != '0)))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (k_reg == K_W'(DEPTH) && !rdv_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (bc_reg == BC_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    if ((norm_reg && it_reg.row_end && it_dmin != '0)
                        || (!norm_reg && d_reg > S_W'(1)))
                    begin
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rdv_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= (state_reg == ST_ACC) && (k_reg < K_W'(DEPTH));
            if (q_pop)
            begin
                wp_reg <= wp_next;
            end
            if (state_reg == ST_SETUP)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_ACC && k_reg < K_W'(DEPTH))
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kd_reg <= k_reg;
        if (q_pop)
        begin
            it_reg   <= q_item;
            norm_reg <= q_norm;
            d_reg    <= q_dmin;
        end
        if (state_reg == ST_SETUP)
        begin
            rlo_reg  <= norm_reg ? IDX_W'(1) : '0;
            rhi_reg  <= norm_reg ? IDX_W'(it_reg.s) : IDX_W'(d_reg) - 1'b1;
            ra_reg   <= norm_reg ? it_reg.a : '0;
            rw_reg   <= norm_reg ? {it_reg.s, it_reg.a} : {d_reg, 8'b0};
            llo_reg  <= e_c;
            rsum_reg <= '0;
            lsum_reg <= '0;
            if (x_c >= IDX_W'(it_reg.s))
            begin
                lhi_reg <= e_c + IDX_W'(it_reg.s) - 1'b1;
                lf_reg  <= e_c + IDX_W'(it_reg.s);
                la_reg  <= it_reg.a;
                lw_reg  <= {it_reg.s, it_reg.a};
            end
            else
            begin
                lhi_reg <= e_c + x_c;
                lf_reg  <= '0;
                la_reg  <= '0;
                lw_reg  <= {S_W'(x_c + 1'b1), 8'b0};
            end
        end
        if (state_reg == ST_ACC && rdv_reg)
        begin
            rsum_reg <= rsum_reg + r_add;
            lsum_reg <= lsum_reg + l_add;
        end
        if (state_reg == ST_ACC)
        begin
            rnum_reg <= {rsum_reg, 8'b0};
            lnum_reg <= {lsum_reg, 8'b0};
            rrem_reg <= '0;
            lrem_reg <= '0;
            rq_reg   <= '0;
            lq_reg   <= '0;
            bc_reg   <= BC_W'(NUM_W);
        end
        else if (state_reg == ST_DIV)
        begin
            rnum_reg <= rnum_reg << 1;
            lnum_reg <= lnum_reg << 1;
            rrem_reg <= rbit ? W_W'(rrem_sh - {1'b0, rw_reg}) : W_W'(rrem_sh);
            lrem_reg <= lbit ? W_W'(lrem_sh - {1'b0, lw_reg}) : W_W'(lrem_sh);
            rq_reg   <= {rq_reg[Q_W-2:0], rbit};
            lq_reg   <= {lq_reg[Q_W-2:0], lbit};
            bc_reg   <= bc_reg - 1'b1;
        end
        if (emit_go)
        begin
            out_data_reg <= res_c;
            out_last_reg <= !norm_reg && (d_reg == S_W'(1));
            if (norm_reg)
            begin
                d_reg    <= it_dmin;
                norm_reg <= 1'b0;
            end
            else
            begin
                d_reg <= d_reg - 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

### hw/rtl/box_difference_row_derivative_top.sv
// Top level of the box difference row derivative block.
// Depends on bdrd_pkg, bdrd_front, bdrd_fifo and bdrd_back.
//
// Use: pixels of a row enter on the s_axis channel (tdata = pixel, tlast =
// last pixel of the row). Results leave on m_axis (tdata = derivative
// value, tlast = final result of the row). The filter length (unsigned Q8)
// is written over the APB port at byte address 0 while the block is idle.
// A row of W pixels gives W-1 results: one per pixel once s+1 pixels have
// arrived, the remaining ones flushed after the last pixel.
// Each result sweeps the pixel history memory of 2*MAX_HALF+2 entries
// (one read a cycle), then runs the two serial dividers and the output
// register; each further flush result of the same pixel starts again
// at setup. A pixel that gives no result is only stored in the history. A
// four-entry request queue lets the intake run ahead of the arithmetic.
// Reset sets the filter length to 5.0 and clears the column count; the
// history needs no clearing. When m_axis_tready is low the result holds in
// the output register and the arithmetic waits; the queue then fills and
// s_axis_tready drops.
module box_difference_row_derivative_top #(
    parameter int MAX_HALF = bdrd_pkg::MAX_HALF_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bdrd_pkg::ADDR_W-1:0] paddr,
    input  logic [bdrd_pkg::DATA_W-1:0] pwdata,
    output logic [bdrd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] pixel
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] deriv_value
    output logic                        m_axis_tlast
);
    import bdrd_pkg::*;

    item_t push_item;
    item_t pop_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign pready = 1'b1;

    bdrd_front #(.MAX_HALF(MAX_HALF)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_pixel (s_axis_tdata),
        .in_end   (s_axis_tlast),
        .q_push   (push),
        .q_item   (push_item),
        .q_full   (full)
    );

    bdrd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_item),
        .full  (full),
        .pop   (pop),
        .dout  (pop_item),
        .empty (empty)
    );

    bdrd_back #(.MAX_HALF(MAX_HALF)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (pop_item),
        .q_empty   (empty),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### hw/rtl/bdrd_checker.sv
// Port-level checks for the box difference row derivative block.
// Depends on bdrd_pkg; bound to box_difference_row_derivative_top.
module bdrd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bdrd_pkg::ADDR_W-1:0] paddr,
    input logic [bdrd_pkg::DATA_W-1:0] pwdata,
    input logic [bdrd_pkg::DATA_W-1:0] prdata,
    input logic                        pready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [7:0]                  m_axis_tdata,
    input logic                        m_axis_tlast
);
    import bdrd_pkg::*;

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[DATA_W-1:LEN_W] == '0)
        else $error("prdata upper bits set");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2])
        |=> (!(psel && !pwrite && !paddr[2])
             || prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))
        else $error("filter length readback mismatch");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result request withdrawn");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind box_difference_row_derivative_top bdrd_checker u_bdrd_checker (.*);
